@@ rtl/core/obb_sat_pkg.sv @@
// Package: shared constants and axis tables for the OBB separating axis test.
package obb_sat_pkg;

    // Default coordinate width, 4 fraction bits
    localparam int COORD_BITS_DEF = 16;

    // Corner store layout: box A in entries 0..3, box B in 4..7
    localparam int NUM_CORNERS = 8;
    localparam int NUM_AXES    = 4;
    localparam int SLOT_BITS   = 3;

    typedef logic [SLOT_BITS-1:0] slot_t;

    // Axis i = corner[AXIS_FROM[i]] - corner[AXIS_TO[i]]
    localparam slot_t AXIS_FROM [NUM_AXES] = '{3'd1, 3'd1, 3'd4, 3'd4};
    localparam slot_t AXIS_TO   [NUM_AXES] = '{3'd0, 3'd2, 3'd7, 3'd5};

endpackage

@@ rtl/core/obb_sat_if.sv @@
// Interfaces: corner input channel and collision result channel.
interface obb_sat_corner_if #(
    parameter int COORD_BITS = obb_sat_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         box_select;
    logic [1:0]                   corner_index;
    logic signed [COORD_BITS-1:0] corner_x;
    logic signed [COORD_BITS-1:0] corner_y;
    logic                         last_corner;

    modport source (
        output valid, box_select, corner_index, corner_x, corner_y, last_corner,
        input  ready
    );
    modport sink (
        input  valid, box_select, corner_index, corner_x, corner_y, last_corner,
        output ready
    );
endinterface

interface obb_sat_result_if;
    logic valid;
    logic ready;
    logic colliding;

    modport source (output valid, colliding, input ready);
    modport sink   (input  valid, colliding, output ready);
endinterface

@@ rtl/core/obb_separating_axis_test_core.sv @@
// Top level: corner store, axis formation, four axis pipelines, result register.
//
//  channel  | modport | word                                          | accepted when
//  ---------+---------+-----------------------------------------------+--------------
//  corners  | sink    | box_select, corner_index, corner_x/y, last    | valid & ready
//  result   | source  | colliding                                     | valid & ready
//
// One corner word is taken every cycle while ready is high; each writes the eight-entry
// store, and a word marked last also starts a test: the accepting edge loads the axis
// stage, then projection, two min/max stages, overlap and the result register follow
// in order, each held while the pipeline stalls.
// Reset clears the pipeline valid bits and the result valid; the store is
// not cleared. The whole pipeline stalls while a result waits, and ready is low.
module obb_separating_axis_test_core #(
    parameter int COORD_BITS = obb_sat_pkg::COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    obb_sat_corner_if.sink             corners,
    obb_sat_result_if.source           result
);
    import obb_sat_pkg::*;

    localparam int STAGES = 5;  // s1 axis, projection, pair, extent, overlap

    logic                         adv;
    logic                         acc;
    slot_t                        slot;
    logic signed [COORD_BITS-1:0] store_x_reg  [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] store_y_reg  [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] store_x_next [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] store_y_next [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] snap_x_reg   [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] snap_y_reg   [NUM_CORNERS];
    logic signed [COORD_BITS:0]   axis_x_reg   [NUM_AXES];
    logic signed [COORD_BITS:0]   axis_y_reg   [NUM_AXES];
    logic [NUM_AXES-1:0]          overlap;
    logic [STAGES-1:0]            vpipe_reg;
    logic                         out_valid_reg;
    logic                         colliding_reg;

    // Handshake: everything moves when the result register is free or being read
    assign adv  = !out_valid_reg || result.ready;
    assign acc  = corners.valid && adv;
    assign slot = {corners.box_select, corners.corner_index};
    assign corners.ready = adv;

    // Store with the incoming corner merged in
    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            if (acc && (slot == slot_t'(i)))
            begin
                store_x_next[i] = corners.corner_x;
                store_y_next[i] = corners.corner_y;
            end
            else
            begin
                store_x_next[i] = store_x_reg[i];
                store_y_next[i] = store_y_reg[i];
            end
        end
    end

    // Corner store and snapshot with edge vectors
    always_ff @(posedge clk)
    begin
        store_x_reg <= store_x_next;
        store_y_reg <= store_y_next;
        if (adv)
        begin
            snap_x_reg <= store_x_next;
            snap_y_reg <= store_y_next;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                axis_x_reg[a] <= {store_x_next[AXIS_FROM[a]][COORD_BITS-1],
                                  store_x_next[AXIS_FROM[a]]}
                               - {store_x_next[AXIS_TO[a]][COORD_BITS-1],
                                  store_x_next[AXIS_TO[a]]};
                axis_y_reg[a] <= {store_y_next[AXIS_FROM[a]][COORD_BITS-1],
                                  store_y_next[AXIS_FROM[a]]}
                               - {store_y_next[AXIS_TO[a]][COORD_BITS-1],
                                  store_y_next[AXIS_TO[a]]};
            end
        end
    end

    // Axis pipelines
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        obb_sat_axis #(
            .COORD_BITS(COORD_BITS)
        ) u_axis (
            .clk     (clk),
            .en      (adv),
            .axis_x  (axis_x_reg[a]),
            .axis_y  (axis_y_reg[a]),
            .cx      (snap_x_reg),
            .cy      (snap_y_reg),
            .overlap (overlap[a])
        );
    end

    // Valid pipeline and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vpipe_reg     <= {vpipe_reg[STAGES-2:0], acc && corners.last_corner};
            out_valid_reg <= vpipe_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            colliding_reg <= &overlap;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.colliding = colliding_reg;

`ifndef SYNTHESIS
    // A corner without the last mark starts no test
    a_no_test_without_last: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !corners.last_corner) |=> !vpipe_reg[0])
        else $error("test started by a corner without the last mark");

    // A last corner always starts a test
    a_last_starts_test: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && corners.last_corner) |=> vpipe_reg[0])
        else $error("last corner did not start a test");

    // The pipeline holds while stalled
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vpipe_reg))
        else $error("pipeline moved during a stall");

    // A new result only comes from the final stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vpipe_reg[STAGES-1]))
        else $error("result valid without a finished test");
`endif

endmodule

@@ rtl/core/obb_sat_axis.sv @@
// Per-axis pipeline: projects eight corners, finds box extents, flags overlap.
module obb_sat_axis #(
    parameter int COORD_BITS = obb_sat_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS:0]   axis_x,
    input  logic signed [COORD_BITS:0]   axis_y,
    input  logic signed [COORD_BITS-1:0] cx [obb_sat_pkg::NUM_CORNERS],
    input  logic signed [COORD_BITS-1:0] cy [obb_sat_pkg::NUM_CORNERS],
    output logic                         overlap
);
    import obb_sat_pkg::*;

    localparam int PW = 2 * COORD_BITS + 1;  // one product
    localparam int SW = 2 * COORD_BITS + 2;  // sum of two products

    logic signed [PW-1:0] px [NUM_CORNERS];
    logic signed [PW-1:0] py [NUM_CORNERS];
    logic signed [SW-1:0] proj_next [NUM_CORNERS];
    logic signed [SW-1:0] proj_reg  [NUM_CORNERS];
    logic signed [SW-1:0] pair_lo_reg [4];
    logic signed [SW-1:0] pair_hi_reg [4];
    logic signed [SW-1:0] box_lo_reg  [2];
    logic signed [SW-1:0] box_hi_reg  [2];
    logic                 overlap_reg;

    // Dot product of each corner with the axis, exact width
    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            px[c] = cx[c] * axis_x;
            py[c] = cy[c] * axis_y;
            proj_next[c] = {px[c][PW-1], px[c]} + {py[c][PW-1], py[c]};
        end
    end

    // Projection stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            proj_reg <= proj_next;
        end
    end

    // Pairwise min/max: pairs (0,1) and (2,3) of each box
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < 4; p++)
            begin
                if (proj_reg[2*p+1] < proj_reg[2*p])
                begin
                    pair_lo_reg[p] <= proj_reg[2*p+1];
                    pair_hi_reg[p] <= proj_reg[2*p];
                end
                else
                begin
                    pair_lo_reg[p] <= proj_reg[2*p];
                    pair_hi_reg[p] <= proj_reg[2*p+1];
                end
            end
        end
    end

    // Box extents along the axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 2; b++)
            begin
                box_lo_reg[b] <= (pair_lo_reg[2*b+1] < pair_lo_reg[2*b]) ?
                                 pair_lo_reg[2*b+1] : pair_lo_reg[2*b];
                box_hi_reg[b] <= (pair_hi_reg[2*b] < pair_hi_reg[2*b+1]) ?
                                 pair_hi_reg[2*b+1] : pair_hi_reg[2*b];
            end
        end
    end

    // Strict overlap; touching extents count as separated
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            overlap_reg <= (box_lo_reg[1] < box_hi_reg[0]) &&
                           (box_lo_reg[0] < box_hi_reg[1]);
        end
    end

    assign overlap = overlap_reg;

endmodule

@@ dv/obb_sat_checker.sv @@
// Checker: predicts the collision flag of each test and compares it with the result channel.
`timescale 1ns / 1ps
module obb_sat_checker #(
    parameter int CB = obb_sat_pkg::COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    obb_sat_corner_if corners,
    obb_sat_result_if result,
    output int        fail_count,
    output int        pending,
    output int        tests_done,
    output int        hits
);
    import obb_sat_pkg::*;

    typedef logic signed [CB-1:0]   coord_t;
    typedef logic signed [CB:0]     edge_t;
    typedef logic signed [2*CB+1:0] dot_t;

    // Edge vectors used as axes: head corner minus tail corner
    localparam int EDGE_HEAD [NUM_AXES] = '{1, 1, 4, 4};
    localparam int EDGE_TAIL [NUM_AXES] = '{0, 2, 7, 5};

    coord_t corner_x_mem [NUM_CORNERS];
    coord_t corner_y_mem [NUM_CORNERS];
    bit     colliding_due [$];

    // Projection interval of one box onto an axis
    function automatic void box_span(input int box, input edge_t ex, input edge_t ey,
                                     output dot_t lo, output dot_t hi);
        dot_t p;
        for (int k = 0; k < 4; k++)
        begin
            p = dot_t'(corner_x_mem[box*4+k]) * dot_t'(ex)
              + dot_t'(corner_y_mem[box*4+k]) * dot_t'(ey);
            if (k == 0 || p < lo)
                lo = p;
            if (k == 0 || p > hi)
                hi = p;
        end
    endfunction

    // Boxes overlap unless on some axis their intervals are disjoint or only touch
    function automatic bit boxes_overlap();
        edge_t ex, ey;
        dot_t  lo_a, hi_a, lo_b, hi_b;
        bit    hit;
        hit = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            ex = edge_t'(corner_x_mem[EDGE_HEAD[a]]) - edge_t'(corner_x_mem[EDGE_TAIL[a]]);
            ey = edge_t'(corner_y_mem[EDGE_HEAD[a]]) - edge_t'(corner_y_mem[EDGE_TAIL[a]]);
            box_span(0, ex, ey, lo_a, hi_a);
            box_span(1, ex, ey, lo_b, hi_b);
            // touching or a zero edge counts as separated
            if (!(lo_b < hi_a && lo_a < hi_b))
                hit = 1'b0;
        end
        return hit;
    endfunction

    initial
    begin
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            corner_x_mem[k] = '0;
            corner_y_mem[k] = '0;
        end
    end

    // Watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        bit          want;
        logic [2:0]  slot;
        if (!rst_n)
        begin
            colliding_due.delete();
            fail_count = 0;
            pending    = 0;
            tests_done = 0;
            hits       = 0;
        end
        else
        begin
            // result word against the oldest prediction
            if (result.valid && result.ready)
            begin
                tests_done++;
                if (colliding_due.size() == 0)
                begin
                    $error("colliding: no result expected, got %0b", result.colliding);
                    fail_count++;
                end
                else
                begin
                    want = colliding_due.pop_front();
                    if (result.colliding !== want)
                    begin
                        $error("colliding: expected %0b, got %0b", want, result.colliding);
                        fail_count++;
                    end
                    if (result.colliding === 1'b1)
                        hits++;
                end
            end
            // corner word: store, then test if it closes the set
            if (corners.valid && corners.ready)
            begin
                slot = {corners.box_select, corners.corner_index};
                corner_x_mem[slot] = corners.corner_x;
                corner_y_mem[slot] = corners.corner_y;
                if (corners.last_corner)
                    colliding_due.push_back(boxes_overlap());
            end
            pending = colliding_due.size();
        end
    end

endmodule

@@ dv/tb_obb_separating_axis_test_core.sv @@
// Testbench top: drives corner words and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps
module tb_obb_separating_axis_test_core;

    localparam int CB           = obb_sat_pkg::COORD_BITS_DEF;
    localparam int RANDOM_WORDS = 1250;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending;
    int tests_done;
    int hits;
    int words_sent;
    bit steady;
    bit calm;

    // Planned corner coordinates, slot = box * 4 + corner
    int plan_x [8];
    int plan_y [8];

    obb_sat_corner_if #(.COORD_BITS(CB)) corners_ch ();
    obb_sat_result_if                    result_ch ();

    obb_separating_axis_test_core #(.COORD_BITS(CB)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .corners (corners_ch),
        .result  (result_ch)
    );

    obb_sat_checker #(.CB(CB)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .corners    (corners_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .tests_done (tests_done),
        .hits       (hits)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Drop valid for a pause of length n; called at a falling edge
    task automatic pause(input int n);
        if (n > 0)
        begin
            corners_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Send one corner word and wait for it to be taken
    task automatic send_corner(input bit box, input bit [1:0] idx, input int x, input int y,
                               input bit last);
        if (!steady && $urandom_range(0, 99) < 35)
            pause(idle_len());
        corners_ch.valid        <= 1'b1;
        corners_ch.box_select   <= box;
        corners_ch.corner_index <= idx;
        corners_ch.corner_x     <= x[CB-1:0];
        corners_ch.corner_y     <= y[CB-1:0];
        corners_ch.last_corner  <= last;
        do
            @(posedge clk);
        while (!corners_ch.ready);
        words_sent++;
        @(negedge clk);
    endtask

    // Hold off until every outstanding test has reported
    task automatic drain();
        corners_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Random oriented rectangle with its origin at (cx, cy); sometimes a zero edge
    function automatic void shape_box(input int box, input int cx, input int cy);
        int dx, dy, a, b;
        dx = $urandom_range(0, 80) - 40;
        dy = $urandom_range(0, 80) - 40;
        a  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
        b  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
        plan_x[box*4+0] = cx;
        plan_y[box*4+0] = cy;
        plan_x[box*4+1] = cx + a * dx;
        plan_y[box*4+1] = cy + a * dy;
        plan_x[box*4+2] = cx + a * dx - b * dy;
        plan_y[box*4+2] = cy + a * dy + b * dx;
        plan_x[box*4+3] = cx - b * dy;
        plan_y[box*4+3] = cy + b * dx;
    endfunction

    // Send planned slots in shuffled order, last mark on the final word
    task automatic send_plan(input int first, input int count);
        int order [8];
        int j, t;
        for (int k = 0; k < count; k++)
            order[k] = first + k;
        for (int k = count - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            t        = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < count; k++)
            send_corner(order[k][2], order[k][1:0], plan_x[order[k]], plan_y[order[k]],
                        k == count - 1);
    endtask

    // Result back-pressure: random stalls with calm stretches
    initial
    begin : sink_side
        int hold;
        int ticks;
        hold            = 0;
        ticks           = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            ticks++;
            if (ticks % 200 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                    hold = idle_len();
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int  stop;
        int  pick;
        int  box;
        int  cx, cy;
        bit  drained_once;
        rst_n                   = 1'b0;
        steady                  = 1'b0;
        calm                    = 1'b0;
        words_sent              = 0;
        drained_once            = 1'b0;
        corners_ch.valid        = 1'b0;
        corners_ch.box_select   = 1'b0;
        corners_ch.corner_index = '0;
        corners_ch.corner_x     = '0;
        corners_ch.corner_y     = '0;
        corners_ch.last_corner  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // overlapping axis-aligned squares; first test only once all eight are written
        send_corner(0, 0,   0,   0, 0);
        send_corner(0, 1, 160,   0, 0);
        send_corner(0, 2, 160, 160, 0);
        send_corner(0, 3,   0, 160, 0);
        send_corner(1, 0,  80,  80, 0);
        send_corner(1, 1, 240,  80, 0);
        send_corner(1, 2, 240, 240, 0);
        send_corner(1, 3,  80, 240, 1);
        // box B only touching box A
        send_corner(1, 0, 160,   0, 0);
        send_corner(1, 1, 320,   0, 0);
        send_corner(1, 2, 320, 160, 0);
        send_corner(1, 3, 160, 160, 1);
        // both boxes spanning the full coordinate range
        send_corner(0, 0, -32768, -32768, 0);
        send_corner(0, 1,  32767, -32768, 0);
        send_corner(0, 2,  32767,  32767, 0);
        send_corner(0, 3, -32768,  32767, 0);
        send_corner(1, 0, -32768, -32768, 0);
        send_corner(1, 1,  32767, -32768, 0);
        send_corner(1, 2,  32767,  32767, 0);
        send_corner(1, 3, -32768,  32767, 1);
        // zero edge on box A
        send_corner(0, 1, -32768, -32768, 1);
        // restore without a test, then test again
        send_corner(0, 1,  32767, -32768, 0);
        send_corner(1, 2,  32767,  32767, 1);

        // random part: mostly full box pairs, some single-box updates, some noise
        stop = words_sent + RANDOM_WORDS;
        while (words_sent < stop)
        begin
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            if (!drained_once && words_sent > stop - RANDOM_WORDS / 2)
            begin
                drain();
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                cx = $urandom_range(0, 16000) - 8000;
                cy = $urandom_range(0, 16000) - 8000;
                shape_box(0, cx, cy);
                shape_box(1, cx + $urandom_range(0, 3000) - 1500,
                          cy + $urandom_range(0, 3000) - 1500);
                send_plan(0, 8);
            end
            else if (pick < 80)
            begin
                box = $urandom_range(0, 1);
                shape_box(box, plan_x[(1-box)*4] + $urandom_range(0, 3000) - 1500,
                          plan_y[(1-box)*4] + $urandom_range(0, 3000) - 1500);
                send_plan(box * 4, 4);
            end
            else
                send_corner($urandom_range(0, 1), $urandom_range(0, 3), $urandom, $urandom,
                            $urandom_range(0, 2) == 0);
        end

        // wind down
        drain();
        repeat (20) @(negedge clk);
        $display("Covered %0d corner words and %0d overlap tests (%0d colliding, %0d apart).",
                 words_sent, tests_done, hits, tests_done - hits);
        if (fail_count == 0)
            $display("obb_separating_axis_test_core: match");
        else
            $display("obb_separating_axis_test_core: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("obb_separating_axis_test_core: mismatch");
        $finish;
    end

endmodule
